// File: hw/rtl/adsr_envelope_generator_defines.svh
// Assertion macros for the ADSR envelope generator.
`ifndef ADSR_ENVELOPE_GENERATOR_DEFINES_SVH
`define ADSR_ENVELOPE_GENERATOR_DEFINES_SVH

// Same-cycle implication, reset masked.
`define ADSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset masked.
`define ADSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/adsr_pkg.sv
// Shared constants, types and register map of the ADSR envelope generator.
package adsr_pkg;

  localparam int LEVEL_BITS   = 16;
  localparam int TIME_W       = 17;
  localparam int STAMP_W      = 32;
  localparam int AMP_W        = 16;
  localparam int REQ_W        = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 17;
  localparam int PROD_W       = LEVEL_BITS + TIME_W;
  localparam int ITER_CNT_W   = (LEVEL_BITS > 1) ? $clog2(LEVEL_BITS) : 1;
  localparam int CUTOFF_LEVEL = ((1 << LEVEL_BITS) + 999) / 1000;

  // request kinds; the unused code behaves as a query
  localparam logic [REQ_W-1:0] REQ_QUERY    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 2'd2;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_PEAK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd4;

  localparam logic [15:0]       PEAK_RESET    = 16'd0;
  localparam logic [TIME_W-1:0] ATTACK_RESET  = 17'd22050;
  localparam logic [TIME_W-1:0] DECAY_RESET   = 17'd35280;
  localparam logic [15:0]       SUSTAIN_RESET = 16'd52428;
  localparam logic [TIME_W-1:0] RELEASE_RESET = 17'd57330;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIFE,
    ST_HOLD,
    ST_HOLD_WAIT,
    ST_REL,
    ST_REL_WAIT,
    ST_DONE
  } adsr_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_ITER
  } md_state_t;

  // how a quotient is folded into the level
  typedef enum logic [1:0] {
    MODE_DIRECT,
    MODE_UP,
    MODE_DOWN
  } lvl_mode_t;

  // a * b / d with b <= d, so the quotient fits in LEVEL_BITS
  typedef struct packed {
    logic [LEVEL_BITS-1:0] a;
    logic [TIME_W-1:0]     b;
    logic [TIME_W-1:0]     d;
  } muldiv_op_t;

endpackage

// File: hw/rtl/adsr_req_if.sv
// Request channel: kind of request and its sample time.
interface adsr_req_if import adsr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [STAMP_W-1:0] sample_time;

  modport source (output valid, output req_type, output sample_time, input ready);
  modport sink   (input valid, input req_type, input sample_time, output ready);
endinterface

// File: hw/rtl/adsr_amp_if.sv
// Result channel: envelope amplitude.
interface adsr_amp_if import adsr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AMP_W-1:0] amplitude;

  modport source (output valid, output amplitude, input ready);
  modport sink   (input valid, input amplitude, output ready);
endinterface

// File: hw/rtl/adsr_cfg_if.sv
// Configuration write channel: register index and write data.
interface adsr_cfg_if import adsr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/adsr_envelope_generator.sv
// Linear ADSR envelope generator. Every request (query, note-on or note-off) yields one
// amplitude at its sample time, after any note event has been stored. One request is handled
// at a time; the request channel is not ready until the result has been moved into the output
// register. A request passes through ST_LIFE, ST_HOLD and ST_DONE, and once the note is
// released also ST_REL. When a ramp needs its slope worked out, the request waits for the
// single multiply/divide unit, which produces one quotient bit per cycle; a release ramp
// may need it twice, once for the level held at note-off. A finished result also waits for
// the output register to empty. The output register lets a new request be taken while a
// finished amplitude still waits for its transfer. Configuration writes are taken in any
// cycle but belong to idle periods.
`include "adsr_envelope_generator_defines.svh"

module adsr_envelope_generator import adsr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  adsr_req_if.sink   req,
  adsr_amp_if.source amp,
  adsr_cfg_if.sink   cfg
);

  // configuration
  logic [15:0]       peak_level;
  logic [TIME_W-1:0] attack_samples;
  logic [TIME_W-1:0] decay_samples;
  logic [15:0]       sustain_level;
  logic [TIME_W-1:0] release_samples;

  // note state
  logic               gate_on;
  logic [STAMP_W-1:0] on_time;
  logic [STAMP_W-1:0] off_time;

  // work registers
  adsr_state_t           state;
  adsr_state_t           state_next;
  logic [STAMP_W-1:0]    req_time;
  logic [STAMP_W-1:0]    life;
  logic                  before_on;
  logic [LEVEL_BITS-1:0] level;
  logic [LEVEL_BITS-1:0] level_next;
  logic                  level_load;
  lvl_mode_t             mode;
  lvl_mode_t             mode_next;
  logic                  out_valid;
  logic [LEVEL_BITS-1:0] out_level;
  logic                  out_load;

  logic                  md_start;
  logic                  md_done;
  muldiv_op_t            md_op;
  logic [LEVEL_BITS-1:0] md_q;

  logic [LEVEL_BITS-1:0] pk;
  logic [LEVEL_BITS-1:0] su;
  logic [STAMP_W-1:0]    hold_t;
  logic [TIME_W:0]       ad_sum;
  logic [STAMP_W-1:0]    rel_e;
  logic [LEVEL_BITS-1:0] combined;
  logic [LEVEL_BITS-1:0] cut_level;
  logic                  req_xfer;

  assign pk       = LEVEL_BITS'(peak_level);
  assign su       = LEVEL_BITS'(sustain_level);
  assign hold_t   = gate_on ? req_time : off_time;
  assign ad_sum   = {1'b0, attack_samples} + {1'b0, decay_samples};
  assign rel_e    = (req_time > off_time) ? (req_time - off_time) : '0;
  assign req_xfer = req.valid && req.ready;

  always_comb begin
    case (mode)
      MODE_UP:   combined = pk + md_q;
      MODE_DOWN: combined = pk - md_q;
      default:   combined = md_q;
    endcase
  end

  assign cut_level = (level < LEVEL_BITS'(CUTOFF_LEVEL)) ? '0 : level;

  assign req.ready     = state == ST_IDLE;
  assign cfg.ready     = 1'b1;
  assign amp.valid     = out_valid;
  assign amp.amplitude = AMP_W'(out_level);

  adsr_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .op    (md_op),
    .done  (md_done),
    .q     (md_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_level      <= PEAK_RESET;
      attack_samples  <= ATTACK_RESET;
      decay_samples   <= DECAY_RESET;
      sustain_level   <= SUSTAIN_RESET;
      release_samples <= RELEASE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PEAK:    peak_level      <= cfg.data[15:0];
        REG_ATTACK:  attack_samples  <= cfg.data;
        REG_DECAY:   decay_samples   <= cfg.data;
        REG_SUSTAIN: sustain_level   <= cfg.data[15:0];
        REG_RELEASE: release_samples <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      gate_on  <= 1'b0;
      on_time  <= '0;
      off_time <= '0;
    end else begin
      state <= state_next;
      if (req_xfer) begin
        case (req.req_type)
          REQ_NOTE_ON: begin
            gate_on <= 1'b1;
            on_time <= req.sample_time;
          end
          REQ_NOTE_OFF: begin
            gate_on  <= 1'b0;
            off_time <= req.sample_time;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) req_time <= req.sample_time;
    if (state == ST_LIFE) begin
      before_on <= hold_t < on_time;
      life      <= hold_t - on_time;
    end
    if (level_load) level <= level_next;
    if (md_start) mode <= mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (amp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_level <= cut_level;
  end

  always_comb begin
    state_next = state;
    md_start   = 1'b0;
    md_op      = '0;
    mode_next  = MODE_DIRECT;
    level_next = '0;
    level_load = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: if (req_xfer) state_next = ST_LIFE;
      ST_LIFE: state_next = ST_HOLD;
      ST_HOLD: begin
        if (before_on) begin
          level_load = 1'b1;
          state_next = gate_on ? ST_DONE : ST_REL;
        end else if (attack_samples != '0 && life <= STAMP_W'(attack_samples)) begin
          md_start   = 1'b1;
          md_op.a    = pk;
          md_op.b    = life[TIME_W-1:0];
          md_op.d    = attack_samples;
          state_next = ST_HOLD_WAIT;
        end else if (decay_samples != '0 && life <= STAMP_W'(ad_sum)) begin
          // ramp from peak towards sustain, step truncated towards peak
          md_start   = 1'b1;
          md_op.b    = TIME_W'(life - STAMP_W'(attack_samples));
          md_op.d    = decay_samples;
          if (su >= pk) begin
            md_op.a   = su - pk;
            mode_next = MODE_UP;
          end else begin
            md_op.a   = pk - su;
            mode_next = MODE_DOWN;
          end
          state_next = ST_HOLD_WAIT;
        end else begin
          level_next = su;
          level_load = 1'b1;
          state_next = gate_on ? ST_DONE : ST_REL;
        end
      end
      ST_HOLD_WAIT: begin
        if (md_done) begin
          level_next = combined;
          level_load = 1'b1;
          state_next = gate_on ? ST_DONE : ST_REL;
        end
      end
      ST_REL: begin
        if (release_samples == '0 || rel_e >= STAMP_W'(release_samples)) begin
          level_load = 1'b1;
          state_next = ST_DONE;
        end else begin
          md_start   = 1'b1;
          md_op.a    = level;
          md_op.b    = TIME_W'(STAMP_W'(release_samples) - rel_e);
          md_op.d    = release_samples;
          state_next = ST_REL_WAIT;
        end
      end
      ST_REL_WAIT: begin
        if (md_done) begin
          level_next = combined;
          level_load = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        out_load = !out_valid || amp.ready;
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `ADSR_ASSERT_NEXT(a_busy_after_req, req_xfer, !req.ready, "request taken while busy")
  `ADSR_ASSERT_NOW(a_div_nonzero, md_start, md_op.d != '0, "divide started with zero divisor")
  `ADSR_ASSERT_NOW(a_done_in_wait, md_done, state == ST_HOLD_WAIT || state == ST_REL_WAIT, "divider result unclaimed")
  `ADSR_ASSERT_NOW(a_cutoff, out_valid, out_level == '0 || out_level >= LEVEL_BITS'(CUTOFF_LEVEL), "level below cutoff presented")

endmodule

// File: hw/rtl/adsr_muldiv.sv
// Shared multiply then restoring divide unit: q = a * b / d, one quotient bit per cycle.
module adsr_muldiv import adsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  muldiv_op_t            op,
  output logic                  done,
  output logic [LEVEL_BITS-1:0] q
);

  md_state_t             state;
  md_state_t             state_next;
  muldiv_op_t            op_r;
  logic [PROD_W-1:0]     prod;
  logic [TIME_W-1:0]     rem;
  logic [LEVEL_BITS-1:0] quo;
  logic [ITER_CNT_W-1:0] cnt;
  logic [TIME_W:0]       rem_sh;
  logic                  ge;
  logic                  last;

  assign prod   = PROD_W'(op_r.a) * PROD_W'(op_r.b);
  assign rem_sh = {rem, quo[LEVEL_BITS-1]};
  assign ge     = rem_sh >= {1'b0, op_r.d};
  assign last   = cnt == ITER_CNT_W'(LEVEL_BITS - 1);
  assign q      = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == MD_ITER) && last;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      MD_IDLE: if (start) state_next = MD_MUL;
      MD_MUL:  state_next = MD_ITER;
      MD_ITER: if (last) state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  // upper product bits are already below d, so only LEVEL_BITS steps are needed
  always_ff @(posedge clk) begin
    case (state)
      MD_IDLE: begin
        if (start) op_r <= op;
        cnt <= '0;
      end
      MD_MUL: begin
        rem <= prod[PROD_W-1:LEVEL_BITS];
        quo <= prod[LEVEL_BITS-1:0];
        cnt <= '0;
      end
      MD_ITER: begin
        rem <= ge ? TIME_W'(rem_sh - {1'b0, op_r.d}) : rem_sh[TIME_W-1:0];
        quo <= {quo[LEVEL_BITS-2:0], ge};
        cnt <= cnt + 1'b1;
      end
      default: cnt <= '0;
    endcase
  end

endmodule

// File: test/adsr_envelope_checker.sv
// Envelope checker: predicts the amplitude of every request and compares each result transfer.
module adsr_envelope_checker import adsr_pkg::*; (
  input  logic clk,
  input  logic rst,
  adsr_req_if  req,
  adsr_amp_if  amp,
  adsr_cfg_if  cfg,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [LEVEL_BITS-1:0] peak_q;
  logic [LEVEL_BITS-1:0] sustain_q;
  logic [TIME_W-1:0]     attack_q;
  logic [TIME_W-1:0]     decay_q;
  logic [TIME_W-1:0]     release_q;
  logic                  gate_q;
  logic [STAMP_W-1:0]    on_q;
  logic [STAMP_W-1:0]    off_q;
  logic [AMP_W-1:0]      amp_expected[$];
  logic [AMP_W-1:0]      want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    fail_count++;
  endtask

  // level while the note is held, as seen at time t
  function automatic logic [63:0] held_level(input logic [STAMP_W-1:0] t);
    logic [63:0] pk;
    logic [63:0] su;
    logic [63:0] a;
    logic [63:0] d;
    logic [63:0] life;
    logic [63:0] into;
    pk = 64'(peak_q);
    su = 64'(sustain_q);
    a  = 64'(attack_q);
    d  = 64'(decay_q);
    if (t < on_q) return 64'd0;
    life = 64'(t - on_q);
    if (a != 0 && life <= a) return pk * life / a;
    if (d != 0 && life <= a + d) begin
      into = life - a;
      if (su >= pk) return pk + (su - pk) * into / d;
      return pk - (pk - su) * into / d;
    end
    return su;
  endfunction

  function automatic logic [AMP_W-1:0] envelope_at(input logic [STAMP_W-1:0] t);
    logic [63:0] lvl;
    logic [63:0] start;
    logic [63:0] e;
    logic [63:0] r;
    r = 64'(release_q);
    if (gate_q) begin
      lvl = held_level(t);
    end else begin
      start = held_level(off_q);
      e = (t > off_q) ? 64'(t - off_q) : 64'd0;
      if (r == 0 || e >= r) lvl = 64'd0;
      else lvl = start * (r - e) / r;
    end
    if (lvl < CUTOFF_LEVEL) lvl = 64'd0;
    return lvl[AMP_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      peak_q    = PEAK_RESET;
      attack_q  = ATTACK_RESET;
      decay_q   = DECAY_RESET;
      sustain_q = SUSTAIN_RESET;
      release_q = RELEASE_RESET;
      gate_q    = 1'b0;
      on_q      = '0;
      off_q     = '0;
      amp_expected.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_PEAK:    peak_q    = cfg.data[LEVEL_BITS-1:0];
          REG_ATTACK:  attack_q  = cfg.data[TIME_W-1:0];
          REG_DECAY:   decay_q   = cfg.data[TIME_W-1:0];
          REG_SUSTAIN: sustain_q = cfg.data[LEVEL_BITS-1:0];
          REG_RELEASE: release_q = cfg.data[TIME_W-1:0];
          default: ;
        endcase
      end
      // note events are stored before the amplitude is worked out
      if (req.valid && req.ready) begin
        case (req.req_type)
          REQ_NOTE_ON: begin
            gate_q = 1'b1;
            on_q   = req.sample_time;
          end
          REQ_NOTE_OFF: begin
            gate_q = 1'b0;
            off_q  = req.sample_time;
          end
          default: ;
        endcase
        amp_expected.push_back(envelope_at(req.sample_time));
      end
      if (amp.valid && amp.ready) begin
        if (amp_expected.size() == 0) begin
          report_mismatch($sformatf("amplitude %0d with no request outstanding",
                                    amp.amplitude));
        end else begin
          want = amp_expected.pop_front();
          if (amp.amplitude !== want)
            report_mismatch($sformatf("amplitude %0d, predicted %0d", amp.amplitude, want));
        end
      end
    end
    pending = amp_expected.size();
  end

endmodule

// File: test/tb_adsr_envelope_generator.sv
// Testbench top: clock, reset, request and register stimulus, result-side stalls and verdict.
module tb_adsr_envelope_generator import adsr_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [REQ_W-1:0]      REQ_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0]  REG_UNUSED = 3'd5;
  localparam logic [CFG_IDX_W-1:0]  REG_TOP    = 3'd7;
  localparam int                    MAX_LEN    = 88200;
  localparam logic [CFG_DATA_W-1:0] MAX_LEVEL  = 17'd65535;
  localparam int                    PHASES     = 8;
  localparam int                    PHASE_LEN  = 112;

  logic clk = 1'b0;
  logic rst;

  adsr_req_if req();
  adsr_amp_if amp();
  adsr_cfg_if cfg();

  int fail_count;
  int pending;
  int items_sent;
  int rx_hold;
  bit tx_idle_en;
  bit rx_idle_en;
  int cur_attack;
  int cur_decay;
  int cur_release;

  always #5 clk = ~clk;

  adsr_envelope_generator u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .amp (amp),
    .cfg (cfg)
  );

  adsr_envelope_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .amp        (amp),
    .cfg        (cfg),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result side: ready with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      amp.ready <= 1'b0;
      rx_hold   <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      amp.ready <= 1'b0;
      rx_hold   <= $urandom_range(0, 16);
    end else begin
      amp.ready <= 1'b1;
    end
  end

  // called at a rising edge; returns at the edge of the transfer, valid left high
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [STAMP_W-1:0] t);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.req_type    <= kind;
    req.sample_time <= t;
    do @(negedge clk); while (!req.ready);
    @(posedge clk);
    items_sent++;
  endtask

  // stop sending and wait until every amplitude has been transferred
  task automatic settle();
    req.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(negedge clk); while (!cfg.ready);
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] pk, input int atk, input int dcy,
                           input logic [CFG_DATA_W-1:0] sus, input int rel);
    write_reg(REG_PEAK, pk);
    write_reg(REG_ATTACK, atk[CFG_DATA_W-1:0]);
    write_reg(REG_DECAY, dcy[CFG_DATA_W-1:0]);
    write_reg(REG_SUSTAIN, sus);
    write_reg(REG_RELEASE, rel[CFG_DATA_W-1:0]);
    cfg.valid   <= 1'b0;
    cur_attack  = atk;
    cur_decay   = dcy;
    cur_release = rel;
  endtask

  function automatic int rand_len();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return MAX_LEN;
      3, 4:    return $urandom_range(1, 64);
      default: return $urandom_range(0, MAX_LEN);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return MAX_LEVEL;
      2:       return CFG_DATA_W'($urandom_range(0, 200));
      default: return CFG_DATA_W'($urandom_range(0, MAX_LEVEL));
    endcase
  endfunction

  function automatic logic [STAMP_W-1:0] rand_stamp();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1000);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 300000);
      default: return $urandom;
    endcase
  endfunction

  // mostly inside the window of interest, now and then just before its start
  function automatic logic [STAMP_W-1:0] offset_in(input int unsigned span);
    if ($urandom_range(0, 7) == 0) return 32'd0 - 32'($urandom_range(1, 100));
    return $urandom_range(0, span);
  endfunction

  function automatic logic [REQ_W-1:0] query_kind();
    return ($urandom_range(0, 9) == 0) ? REQ_SPARE : REQ_QUERY;
  endfunction

  task automatic note_sequence();
    logic [STAMP_W-1:0] t_on;
    logic [STAMP_W-1:0] t_off;
    int unsigned        span;
    t_on = rand_stamp();
    span = cur_attack + cur_decay + 64;
    send_req(REQ_NOTE_ON, t_on);
    repeat ($urandom_range(1, 8)) send_req(query_kind(), t_on + offset_in(span));
    if ($urandom_range(0, 3) != 0) begin
      t_off = t_on + offset_in(span);
      send_req(REQ_NOTE_OFF, t_off);
      repeat ($urandom_range(1, 8))
        send_req(query_kind(), t_off + offset_in(cur_release + 64));
    end
  endtask

  task automatic run_directed();
    logic [STAMP_W-1:0] on_at;
    logic [STAMP_W-1:0] off_at;
    // reset register values: peak below sustain, so decay climbs
    on_at = 32'd1000;
    send_req(REQ_QUERY, 32'd0);
    send_req(REQ_NOTE_ON, on_at);
    send_req(REQ_QUERY, on_at - 32'd500);
    send_req(REQ_QUERY, on_at + 32'd39690);
    send_req(REQ_QUERY, 32'hFFFF_FFFF);
    send_req(REQ_SPARE, on_at + 32'd60000);
    off_at = on_at + 32'd70000;
    send_req(REQ_NOTE_OFF, off_at);
    send_req(REQ_QUERY, off_at - 32'd1000);
    send_req(REQ_QUERY, off_at + 32'd57329);
    send_req(REQ_QUERY, off_at + 32'd57330);
    // no attack, no release, peak written with an over-wide value
    settle();
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    write_reg(REG_TOP, CFG_DATA_W'($urandom));
    configure(17'h1FFFF, 0, MAX_LEN, MAX_LEVEL, 0);
    send_req(REQ_NOTE_ON, 32'd7);
    send_req(REQ_QUERY, 32'd7);
    send_req(REQ_QUERY, 32'd44107);
    send_req(REQ_QUERY, 32'd88207);
    send_req(REQ_QUERY, 32'd88208);
    send_req(REQ_NOTE_OFF, 32'd100000);
    send_req(REQ_QUERY, 32'd100000);
    // longest attack, no decay, sustain at zero, longest release
    settle();
    configure(MAX_LEVEL, MAX_LEN, 0, '0, MAX_LEN);
    send_req(REQ_NOTE_ON, 32'hFFFF_FF00);
    send_req(REQ_QUERY, 32'hFFFF_FFFF);
    send_req(REQ_NOTE_ON, 32'd0);
    send_req(REQ_QUERY, 32'd88200);
    send_req(REQ_QUERY, 32'd88201);
    send_req(REQ_NOTE_OFF, 32'd44100);
    send_req(REQ_QUERY, 32'd0);
    send_req(REQ_QUERY, 32'd132299);
  endtask

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int target;
    int mode;
    rst             = 1'b1;
    req.valid       = 1'b0;
    req.req_type    = REQ_QUERY;
    req.sample_time = '0;
    cfg.valid       = 1'b0;
    cfg.index       = REG_PEAK;
    cfg.data        = '0;
    items_sent      = 0;
    tx_idle_en      = 1'b1;
    rx_idle_en      = 1'b1;
    cur_attack      = int'(ATTACK_RESET);
    cur_decay       = int'(DECAY_RESET);
    cur_release     = int'(RELEASE_RESET);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      settle();
      configure(rand_level(), rand_len(), rand_len(), rand_level(), rand_len());
      // last phase runs flat out on both sides
      mode       = (p == PHASES - 1) ? 0 : $urandom_range(0, 3);
      tx_idle_en = mode[0];
      rx_idle_en = mode[1];
      target     = items_sent + PHASE_LEN;
      while (items_sent < target) begin
        if ($urandom_range(0, 4) != 0) note_sequence();
        else send_req(REQ_W'($urandom_range(0, 3)), $urandom);
      end
    end

    req.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/adsr_pkg.sv
hw/rtl/adsr_req_if.sv
hw/rtl/adsr_amp_if.sv
hw/rtl/adsr_cfg_if.sv
hw/rtl/adsr_muldiv.sv
hw/rtl/adsr_envelope_generator.sv
test/adsr_envelope_checker.sv
test/tb_adsr_envelope_generator.sv
